FILE: design/terrain_tile_attribute_decoder_macros.svh
// assertion macros for the terrain tile attribute decoder
`ifndef TERRAIN_TILE_ATTRIBUTE_DECODER_MACROS_SVH
`define TERRAIN_TILE_ATTRIBUTE_DECODER_MACROS_SVH

// checked only while out of reset
`define TTAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TTAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ttad_pkg.sv
// shared types and constants for the terrain tile attribute decoder
package ttad_pkg;

    localparam int unsigned LEVELS = 4;
    localparam int unsigned SIZE_X = 64;
    localparam int unsigned SIZE_Z = 64;

    localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned X_W   = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int unsigned Z_W   = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;

    localparam int unsigned LEVEL_OUT_W = 2;
    localparam int unsigned X_OUT_W     = 6;
    localparam int unsigned Z_OUT_W     = 6;
    localparam int unsigned HEIGHT_W    = 8;
    localparam int unsigned IDENT_W     = 16;
    localparam int unsigned CODE_W      = 6;
    localparam int unsigned SHAPE_W     = 4;
    localparam int unsigned ROT_W       = 2;
    localparam int unsigned SET_W       = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;

    localparam logic [WORD_W-1:0] CODE_END      = 16'd0;
    localparam logic [WORD_W-1:0] CODE_HEIGHT   = 16'd1;
    localparam logic [WORD_W-1:0] CODE_OVL_BASE = 16'd2;
    localparam logic [WORD_W-1:0] CODE_OVL_MAX  = 16'd49;
    localparam logic [WORD_W-1:0] CODE_SET_MAX  = 16'd81;

    // last declared field (tile_level) in the lowest bits
    typedef struct packed {
        logic [IDENT_W-1:0]     underlay_ident;
        logic [SET_W-1:0]       tile_settings;
        logic [ROT_W-1:0]       overlay_rotation;
        logic [SHAPE_W-1:0]     overlay_shape;
        logic [CODE_W-1:0]      attr_code;
        logic [IDENT_W-1:0]     overlay_ident;
        logic [HEIGHT_W-1:0]    raw_height;
        logic [Z_OUT_W-1:0]     tile_z;
        logic [X_OUT_W-1:0]     tile_x;
        logic [LEVEL_OUT_W-1:0] tile_level;
    } t_tile_rec;

    localparam int unsigned TDATA_W = $bits(t_tile_rec);

    typedef struct packed {
        logic      valid;
        logic      last;
        t_tile_rec rec;
    } t_tile_out;

    typedef enum logic [4:0] {
        PH_ATTR_FIRST  = 5'b00001,
        PH_ATTR_SECOND = 5'b00010,
        PH_HEIGHT      = 5'b00100,
        PH_OVL_FIRST   = 5'b01000,
        PH_OVL_SECOND  = 5'b10000
    } t_phase;

endpackage

FILE: design/ttad_input_stage.sv
// input byte register of the terrain tile attribute decoder
module ttad_input_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic [ttad_pkg::BYTE_W-1:0] i_tdata,
    input  logic                        i_take,
    output logic                        o_valid,
    output logic [ttad_pkg::BYTE_W-1:0] o_byte
);
    import ttad_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_tready = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_byte   = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_byte <= i_tdata;
        end
    end

endmodule

FILE: design/ttad_parser.sv
// attribute parse state, tile fields and tile walk position
module ttad_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ttad_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_attr_wide,
    output ttad_pkg::t_tile_out         o_res
);
    import ttad_pkg::*;

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_latch, n_latch;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [X_W-1:0]      r_x, n_x;
    logic [Z_W-1:0]      r_z, n_z;
    logic [HEIGHT_W-1:0] r_height, n_height;
    logic [IDENT_W-1:0]  r_overlay, n_overlay;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [SHAPE_W-1:0]  r_shape, n_shape;
    logic [ROT_W-1:0]    r_rot, n_rot;
    logic [SET_W-1:0]    r_settings, n_settings;
    logic [IDENT_W-1:0]  r_underlay, n_underlay;

    logic                w_apply;
    logic                w_finish;
    logic                w_last;
    logic [WORD_W-1:0]   w_code;
    logic [WORD_W-1:0]   w_ovl_off;
    logic [HEIGHT_W-1:0] w_height;

    assign w_code    = (r_phase == PH_ATTR_SECOND) ? {r_latch, i_byte}
                                                   : {{(WORD_W-BYTE_W){1'b0}}, i_byte};
    assign w_ovl_off = w_code - CODE_OVL_BASE;
    assign w_height  = (r_phase == PH_HEIGHT) ? i_byte : r_height;
    assign w_last    = (r_lvl == LVL_W'(LEVELS - 1)) && (r_x == X_W'(SIZE_X - 1))
                    && (r_z == Z_W'(SIZE_Z - 1));

    always_comb begin
        n_phase    = r_phase;
        n_latch    = r_latch;
        n_lvl      = r_lvl;
        n_x        = r_x;
        n_z        = r_z;
        n_height   = r_height;
        n_overlay  = r_overlay;
        n_code     = r_code;
        n_shape    = r_shape;
        n_rot      = r_rot;
        n_settings = r_settings;
        n_underlay = r_underlay;
        w_apply    = 1'b0;
        w_finish   = 1'b0;

        if (i_valid) begin
            case (r_phase)
                PH_ATTR_FIRST: begin
                    if (i_attr_wide) begin
                        n_latch = i_byte;
                        n_phase = PH_ATTR_SECOND;
                    end else begin
                        w_apply = 1'b1;
                    end
                end
                PH_ATTR_SECOND: begin
                    w_apply = 1'b1;
                end
                PH_HEIGHT: begin
                    w_finish = 1'b1;
                end
                PH_OVL_FIRST: begin
                    if (i_attr_wide) begin
                        n_latch = i_byte;
                        n_phase = PH_OVL_SECOND;
                    end else begin
                        n_overlay = {{(IDENT_W-BYTE_W){1'b0}}, i_byte};
                        n_phase   = PH_ATTR_FIRST;
                    end
                end
                PH_OVL_SECOND: begin
                    n_overlay = {r_latch, i_byte};
                    n_phase   = PH_ATTR_FIRST;
                end
                default: begin
                    n_phase = PH_ATTR_FIRST;
                end
            endcase

            if (w_apply) begin
                n_phase = PH_ATTR_FIRST;
                if (w_code == CODE_END) begin
                    w_finish = 1'b1;
                end else if (w_code == CODE_HEIGHT) begin
                    n_phase = PH_HEIGHT;
                end else if (w_code <= CODE_OVL_MAX) begin
                    n_code  = CODE_W'(w_code);
                    n_shape = SHAPE_W'(w_ovl_off >> 2);
                    n_rot   = ROT_W'(w_ovl_off);
                    n_phase = PH_OVL_FIRST;
                end else if (w_code <= CODE_SET_MAX) begin
                    n_settings = SET_W'(w_code - CODE_OVL_MAX);
                end else begin
                    n_underlay = w_code - CODE_SET_MAX;
                end
            end

            if (w_finish) begin
                n_phase    = PH_ATTR_FIRST;
                n_height   = '0;
                n_overlay  = '0;
                n_code     = '0;
                n_shape    = '0;
                n_rot      = '0;
                n_settings = '0;
                n_underlay = '0;
                if (w_last) begin
                    n_lvl = '0;
                    n_x   = '0;
                    n_z   = '0;
                end else if (r_z != Z_W'(SIZE_Z - 1)) begin
                    n_z = r_z + 1'b1;
                end else begin
                    n_z = '0;
                    if (r_x != X_W'(SIZE_X - 1)) begin
                        n_x = r_x + 1'b1;
                    end else begin
                        n_x   = '0;
                        n_lvl = r_lvl + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_res.valid                = w_finish;
        o_res.last                 = w_last;
        o_res.rec.tile_level       = LEVEL_OUT_W'(r_lvl);
        o_res.rec.tile_x           = X_OUT_W'(r_x);
        o_res.rec.tile_z           = Z_OUT_W'(r_z);
        o_res.rec.raw_height       = w_height;
        o_res.rec.overlay_ident    = r_overlay;
        o_res.rec.attr_code        = r_code;
        o_res.rec.overlay_shape    = r_shape;
        o_res.rec.overlay_rotation = r_rot;
        o_res.rec.tile_settings    = r_settings;
        o_res.rec.underlay_ident   = r_underlay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ATTR_FIRST;
            r_latch    <= '0;
            r_lvl      <= '0;
            r_x        <= '0;
            r_z        <= '0;
            r_height   <= '0;
            r_overlay  <= '0;
            r_code     <= '0;
            r_shape    <= '0;
            r_rot      <= '0;
            r_settings <= '0;
            r_underlay <= '0;
        end else begin
            r_phase    <= n_phase;
            r_latch    <= n_latch;
            r_lvl      <= n_lvl;
            r_x        <= n_x;
            r_z        <= n_z;
            r_height   <= n_height;
            r_overlay  <= n_overlay;
            r_code     <= n_code;
            r_shape    <= n_shape;
            r_rot      <= n_rot;
            r_settings <= n_settings;
            r_underlay <= n_underlay;
        end
    end

endmodule

FILE: design/ttad_output_stage.sv
// result word register of the terrain tile attribute decoder
module ttad_output_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttad_pkg::t_tile_out          i_res,
    output logic                         o_free,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [ttad_pkg::TDATA_W-1:0] o_tdata,
    output logic                         o_tlast
);
    import ttad_pkg::*;

    logic      r_valid;
    logic      r_last;
    t_tile_rec r_rec;

    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_rec;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_rec  <= i_res.rec;
            r_last <= i_res.last;
        end
    end

endmodule

FILE: design/terrain_tile_attribute_decoder.sv
// a tile's last byte waits in the input byte register, its word then in the output word register
// throughput: one byte per cycle, held back only when the output word register is full
// a tile of n bytes gives one word; the parse state is updated in the single decode pass
// reset (synchronous, active low) clears both registers, parse state, tile fields and walk
// position; attr_wide returns to 1
module terrain_tile_attribute_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data,      // attr_wide
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ttad_pkg::BYTE_W-1:0]  s_axis_tdata,    // in_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tile_level, tile_x, tile_z, raw_height, overlay_ident, attr_code,
    // overlay_shape, overlay_rotation, tile_settings, underlay_ident
    output logic [ttad_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tlast     // last_tile
);
    import ttad_pkg::*;

    logic              r_attr_wide;
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_out_free;
    logic              w_take;
    t_tile_out         w_res;

    assign o_cfg_ready = 1'b1;
    assign w_take      = w_in_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_wide <= 1'b1;
        end else if (i_cfg_valid) begin
            r_attr_wide <= i_cfg_data;
        end
    end

    ttad_input_stage u_input (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_take   (w_take),
        .o_valid  (w_in_valid),
        .o_byte   (w_in_byte)
    );

    ttad_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_take),
        .i_byte      (w_in_byte),
        .i_attr_wide (r_attr_wide),
        .o_res       (w_res)
    );

    ttad_output_stage u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (w_res),
        .o_free   (w_out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

FILE: design/ttad_checker.sv
// port level checks for the terrain tile attribute decoder
`include "terrain_tile_attribute_decoder_macros.svh"

module ttad_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic                         i_cfg_data,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [ttad_pkg::BYTE_W-1:0]  s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ttad_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast
);
    import ttad_pkg::*;

    t_tile_rec w_rec;
    logic      w_unused;

    assign w_rec    = m_axis_tdata;
    assign w_unused = ^{i_cfg_valid, o_cfg_ready, i_cfg_data, s_axis_tvalid,
                        s_axis_tready, s_axis_tdata};

    `TTAD_ASSERT_ALWAYS(a_no_word_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "word valid right after reset")

    `TTAD_ASSERT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled word changed")

    `TTAD_ASSERT(a_field_range, i_clk, i_rst_n, m_axis_tvalid |-> (w_rec.attr_code <= CODE_W'(CODE_OVL_MAX)) && (w_rec.tile_settings <= SET_W'(32)) && (w_rec.overlay_shape <= SHAPE_W'(11)), "decoded field out of range")

    `TTAD_ASSERT(a_overlay_consistent, i_clk, i_rst_n, m_axis_tvalid && (w_rec.attr_code != '0) |-> {w_rec.overlay_shape, w_rec.overlay_rotation} == (w_rec.attr_code - CODE_W'(CODE_OVL_BASE)), "shape and rotation disagree with code")

    `TTAD_ASSERT(a_last_at_end, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast |-> (w_rec.tile_level == LEVEL_OUT_W'(LEVELS - 1)) && (w_rec.tile_x == X_OUT_W'(SIZE_X - 1)) && (w_rec.tile_z == Z_OUT_W'(SIZE_Z - 1)), "last tile flagged away from map end")

endmodule

bind terrain_tile_attribute_decoder ttad_checker u_checker (.*);
